// ----- sv/cf_pkg.sv -----
`default_nettype none

package cf_pkg;

	// Width of the capacity register, fixed by the register map.
	localparam int CFG_W = 5;

	// Capacity after reset.
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	// APB port geometry: one 32-bit register word.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Register word index, taken from the byte address.
	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0
	} cf_reg_t;

	// Operation carried with each request.
	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} cf_func_t;

	// Operation presented to the slot store.
	typedef struct packed {
		logic     fire;
		cf_func_t func;
	} cf_op_t;

	// Status flags returned by the slot store for one operation.
	typedef struct packed {
		logic popped_valid;
		logic conflated;
		logic evicted;
		logic is_empty;
		logic is_full;
	} cf_flags_t;

endpackage

`default_nettype wire

// ----- sv/cf_apb.sv -----
`default_nettype none

module cf_apb (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cf_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [cf_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [cf_pkg::APB_DATA_W-1:0] prdata,
	output logic                               pready,
	output logic      [cf_pkg::CFG_W-1:0]      capacity
);
	import cf_pkg::*;

	logic            wr_en;
	cf_reg_t         reg_idx;
	logic [CFG_W-1:0] capacity_q;

	// The register word is selected by the address above the byte offset.
	assign reg_idx = cf_reg_t'(paddr[APB_ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (wr_en && reg_idx == REG_CAPACITY) begin
			capacity_q <= pwdata[CFG_W-1:0];
		end
	end

	// Read-back decoder.
	always_comb begin
		unique case (reg_idx)
			REG_CAPACITY: prdata = APB_DATA_W'(capacity_q);
			default:      prdata = '0;
		endcase
	end

	assign capacity = capacity_q;

endmodule

`default_nettype wire

// ----- sv/cf_store.sv -----
`default_nettype none

module cf_store #(
	parameter int DEPTH       = 16,
	parameter int KEY_WIDTH   = 16,
	parameter int VALUE_WIDTH = 32,
	localparam int IDX_W      = $clog2(DEPTH),
	localparam int CNT_W      = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cf_pkg::cf_op_t           op,
	input  wire logic [KEY_WIDTH-1:0]     key,
	input  wire logic [VALUE_WIDTH-1:0]   value,
	input  wire logic [cf_pkg::CFG_W-1:0] capacity,
	output logic      [KEY_WIDTH-1:0]     popped_key,
	output logic      [VALUE_WIDTH-1:0]   popped_value,
	output logic      [CNT_W-1:0]         entry_count,
	output cf_pkg::cf_flags_t             flags
);
	import cf_pkg::*;

	localparam int CAPW  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int SUM_W = CNT_W + 1;

	logic [KEY_WIDTH-1:0]   keys_q   [DEPTH];
	logic [VALUE_WIDTH-1:0] values_q [DEPTH];
	logic [DEPTH-1:0]       occ_q;
	logic [IDX_W-1:0]       head_q;
	logic [CNT_W-1:0]       count_q;

	logic [DEPTH-1:0] hit;
	logic             hit_any;
	logic             is_push;
	logic             push_hit;
	logic             push_new;
	logic             evict;
	logic             do_pop;
	logic [CAPW-1:0]  cap_ext;
	logic [CAPW-1:0]  eff_cap;
	logic             full_now;
	logic [IDX_W-1:0] head_inc;
	logic [IDX_W-1:0] head_next;
	logic [SUM_W-1:0] tail_sum;
	logic [IDX_W-1:0] tail_idx;
	logic [CNT_W-1:0] count_next;

	// Effective capacity: zero acts as one, anything above the depth as the depth.
	assign cap_ext = CAPW'(capacity);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CAPW'(1);
		end else if (cap_ext > CAPW'(DEPTH)) begin
			eff_cap = CAPW'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end

	// Parallel key compare against every occupied slot.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit[i] = occ_q[i] && (keys_q[i] == key);
		end
	end
	assign hit_any = |hit;

	// Classify the operation.
	assign is_push  = (op.func == FUNC_PUSH);
	assign full_now = CAPW'(count_q) >= eff_cap;
	assign push_hit = is_push & hit_any;
	assign push_new = is_push & ~hit_any;
	assign evict    = push_new & full_now;
	assign do_pop   = ~is_push & (count_q != '0);

	// Ring pointers. The tail slot is head plus count whether or not the
	// oldest entry is evicted, since eviction moves both by one.
	assign head_inc  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_next = (evict | do_pop) ? head_inc : head_q;
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
	                                               : IDX_W'(tail_sum);

	// Count after the operation.
	always_comb begin
		if (push_new && !evict) begin
			count_next = count_q + 1'b1;
		end else if (do_pop) begin
			count_next = count_q - 1'b1;
		end else begin
			count_next = count_q;
		end
	end

	// Result for this operation.
	assign popped_key         = do_pop ? keys_q[head_q] : '0;
	assign popped_value       = do_pop ? values_q[head_q] : '0;
	assign entry_count        = count_next;
	assign flags.popped_valid = do_pop;
	assign flags.conflated    = push_hit;
	assign flags.evicted      = evict;
	assign flags.is_empty     = (count_next == '0);
	assign flags.is_full      = CAPW'(count_next) >= eff_cap;

	// Control state: occupancy bits, head pointer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			head_q  <= '0;
			count_q <= '0;
		end else if (op.fire) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (push_new && tail_idx == IDX_W'(i)) begin
					occ_q[i] <= 1'b1;
				end else if ((evict || do_pop) && head_q == IDX_W'(i)) begin
					occ_q[i] <= 1'b0;
				end
			end
			head_q  <= head_next;
			count_q <= count_next;
		end
	end

	// Slot payload: a new key goes to the tail, a repeated key updates in place.
	always_ff @(posedge clk) begin
		if (op.fire) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (push_new && tail_idx == IDX_W'(i)) begin
					keys_q[i]   <= key;
					values_q[i] <= value;
				end else if (push_hit && hit[i]) begin
					values_q[i] <= value;
				end
			end
		end
	end

	// The occupancy bits always agree with the count.
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_q) == int'(count_q))
		else $error("occupancy bits disagree with entry count");

	// A key is never pending in two slots.
	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("key matched more than one slot");

	// The head slot holds an entry whenever the queue is not empty.
	a_head_occ: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> occ_q[head_q])
		else $error("head slot empty while entries pending");

	// A pop of a non-empty queue removes exactly one entry.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		op.fire && do_pop |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not reduce the count by one");

endmodule

`default_nettype wire

// ----- sv/conflating_fifo.sv -----
// Conflating FIFO: a queue of key/value entries holding at most one entry per key.
// A request accepted into the input register passes through the slot store into the
// result register, which drives m_tdata; both hold while m_tready stalls the result.
// Throughput: one request per cycle while the result is not stalled; key match and ring
// update are a single combinational pass between the input and result registers.
// Reset empties the queue and sets the capacity register to 16.
`default_nettype none

module conflating_fifo #(
	parameter int DEPTH       = 16,
	parameter int KEY_WIDTH   = 16,
	parameter int VALUE_WIDTH = 32,
	localparam int CNT_W      = $clog2(DEPTH + 1),
	localparam int IN_DW      = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
	localparam int OUT_FW     = KEY_WIDTH + VALUE_WIDTH + CNT_W + 5,
	localparam int OUT_DW     = ((OUT_FW + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cf_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [cf_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [cf_pkg::APB_DATA_W-1:0] prdata,
	output logic                               pready,
	// Request stream.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [IN_DW-1:0]              s_tdata,  // item_key, item_value
	input  wire logic                          s_tuser,  // func
	// Result stream.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// popped_valid, popped_key, popped_value, conflated, evicted, entry_count,
	// is_empty, is_full
	output logic      [OUT_DW-1:0]             m_tdata
);
	import cf_pkg::*;

	logic                   advance;
	logic                   s1_valid;
	cf_func_t               s1_func;
	logic [KEY_WIDTH-1:0]   s1_key;
	logic [VALUE_WIDTH-1:0] s1_value;

	logic [CFG_W-1:0]       capacity;
	cf_op_t                 op;
	logic [KEY_WIDTH-1:0]   popped_key;
	logic [VALUE_WIDTH-1:0] popped_value;
	logic [CNT_W-1:0]       entry_count;
	cf_flags_t              flags;

	logic                   m_valid_q;
	logic [KEY_WIDTH-1:0]   res_key_q;
	logic [VALUE_WIDTH-1:0] res_value_q;
	logic [CNT_W-1:0]       res_count_q;
	cf_flags_t              res_flags_q;

	// The result register moves on when it is empty or being taken.
	assign advance  = ~m_valid_q | m_tready;
	assign s_tready = ~s1_valid | advance;

	// Configuration register.
	cf_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_func  <= cf_func_t'(s_tuser);
			s1_key   <= s_tdata[KEY_WIDTH-1:0];
			s1_value <= s_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
		end
	end

	// Slot store: match, update and result in one pass.
	assign op.fire = s1_valid & advance;
	assign op.func = s1_func;

	cf_store #(
		.DEPTH       (DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.key          (s1_key),
		.value        (s1_value),
		.capacity     (capacity),
		.popped_key   (popped_key),
		.popped_value (popped_value),
		.entry_count  (entry_count),
		.flags        (flags)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op.fire) begin
			res_key_q   <= popped_key;
			res_value_q <= popped_value;
			res_count_q <= entry_count;
			res_flags_q <= flags;
		end
	end

	// Pack the result, first field in the lowest bits.
	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DW'({res_flags_q.is_full, res_flags_q.is_empty, res_count_q,
	                           res_flags_q.evicted, res_flags_q.conflated, res_value_q,
	                           res_key_q, res_flags_q.popped_valid});

endmodule

`default_nettype wire

// ----- bench/conflating_fifo_tb.sv -----
`timescale 1ns / 100ps

module conflating_fifo_tb;
	import cf_pkg::*;

	localparam int QDEPTH     = 16;
	localparam int IN_DW      = 48;
	localparam int OUT_DW     = 64;
	localparam int IDLE_LIMIT = 5000;
	localparam int RAND_ITEMS = 1350;

	// One result word as it leaves on m_tdata, lowest field last.
	typedef struct packed {
		logic [5:0]  pad;
		logic        is_full;
		logic        is_empty;
		logic [4:0]  entry_count;
		logic        evicted;
		logic        conflated;
		logic [31:0] popped_value;
		logic [15:0] popped_key;
		logic        popped_valid;
	} fifo_result_t;

	typedef enum {ROW_REQ, ROW_CAP} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		cf_func_t     func;
		logic [15:0]  key;
		logic [31:0]  value;
		bit           typed;
		fifo_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid, s_tready;
	logic [IN_DW-1:0] s_tdata;   // item_key, item_value
	logic s_tuser;               // func
	logic m_tvalid, m_tready;
	// popped_valid, popped_key, popped_value, conflated, evicted, entry_count,
	// is_empty, is_full
	logic [OUT_DW-1:0] m_tdata;

	// Shadow of the queue and of the capacity register.
	logic [15:0] slot_key [QDEPTH];
	logic [31:0] slot_val [QDEPTH];
	bit          slot_busy [QDEPTH];
	int          head, fill;
	logic [4:0]  cap_reg;

	fifo_result_t result_q [$];
	stim_row_t    dir_tab [$];
	int mismatches, n_results;
	int n_push, n_pop, n_conf, n_evict, n_empty_pop, n_cfg;
	int burst_left, idle_cycles, pat_age;
	bit no_stall;
	logic [15:0] stall_pat;
	logic [15:0] key_pool [24];
	int phase_caps [10] = '{16, 3, 1, 0, 31, 8, 17, 2, 16, 12};

	conflating_fifo i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one request to the shadow queue and returns the result it should give.
	function automatic fifo_result_t predict_result(cf_func_t f, logic [15:0] key,
			logic [31:0] val);
		fifo_result_t r;
		int eff_cap;
		int hit;
		int tail;
		r = '0;
		eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > QDEPTH) ? QDEPTH : int'(cap_reg));
		if (f == FUNC_PUSH) begin
			n_push++;
			hit = -1;
			for (int i = 0; i < QDEPTH; i++)
				if (hit < 0 && slot_busy[i] && slot_key[i] == key)
					hit = i;
			if (hit >= 0) begin
				// A pending key keeps its place; only the value changes.
				slot_val[hit] = val;
				r.conflated = 1'b1;
				n_conf++;
			end else begin
				if (fill >= eff_cap) begin
					slot_busy[head] = 1'b0;
					head = (head + 1) % QDEPTH;
					fill--;
					r.evicted = 1'b1;
					n_evict++;
				end
				tail = (head + fill) % QDEPTH;
				slot_key[tail] = key;
				slot_val[tail] = val;
				slot_busy[tail] = 1'b1;
				fill++;
			end
		end else begin
			n_pop++;
			if (fill > 0) begin
				r.popped_valid = 1'b1;
				r.popped_key = slot_key[head];
				r.popped_value = slot_val[head];
				slot_busy[head] = 1'b0;
				head = (head + 1) % QDEPTH;
				fill--;
			end else begin
				n_empty_pop++;
			end
		end
		r.entry_count = fill[4:0];
		r.is_empty = (fill == 0);
		r.is_full = (fill >= eff_cap);
		return r;
	endfunction

	// A result written out by hand for the directed table.
	function automatic fifo_result_t outcome(bit pv, logic [15:0] k, logic [31:0] v,
			bit conf, bit ev, int cnt, bit full);
		fifo_result_t r;
		r = '0;
		r.popped_valid = pv;
		r.popped_key = k;
		r.popped_value = v;
		r.conflated = conf;
		r.evicted = ev;
		r.entry_count = cnt[4:0];
		r.is_empty = (cnt == 0);
		r.is_full = full;
		return r;
	endfunction

	function automatic stim_row_t req_row(cf_func_t f, logic [15:0] k, logic [31:0] v,
			bit typed, fifo_result_t want);
		stim_row_t r;
		r.kind = ROW_REQ;
		r.func = f;
		r.key = k;
		r.value = v;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t cap_row(int value);
		stim_row_t r;
		r = req_row(FUNC_PUSH, '0, 32'(value), 1'b0, '0);
		r.kind = ROW_CAP;
		return r;
	endfunction

	// Sends one request in the current burst; unless stalls are off, a new burst may open with a gap.
	task automatic send_req(cf_func_t f, logic [15:0] k, logic [31:0] v, bit typed,
			fifo_result_t want);
		int gap;
		fifo_result_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (!no_stall && $urandom_range(0, 2) != 0) begin
				gap = $urandom_range(1, 6);
				repeat (gap) begin
					@(negedge clk);
					s_tvalid <= 1'b0;
				end
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {v, k};
		do @(posedge clk); while (!s_tready);
		pred = predict_result(f, k, v);
		result_q.push_back(typed ? want : pred);
	endtask

	// Holds the sender off until every result is back and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the capacity register, then reads it back.
	task automatic write_capacity(logic [4:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(REG_CAPACITY) << 2;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cap_reg = value;
		n_cfg++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== value) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Capacity read back as %0d, expected %0d", prdata[CFG_W-1:0], value);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Unless stalls are off, the receiver stalls on a rotating pattern that is reloaded now and then.
	always @(negedge clk) begin
		if (pat_age == 0) begin
			stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
			pat_age = $urandom_range(16, 96);
		end
		pat_age--;
		stall_pat = {stall_pat[0], stall_pat[15:1]};
		m_tready <= no_stall | stall_pat[0];
	end

	// Each result is checked against the oldest outstanding expectation.
	always @(posedge clk) begin
		fifo_result_t got, want;
		string bad;
		if (arst_n && m_tvalid && m_tready) begin
			got = fifo_result_t'(m_tdata);
			n_results++;
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result %0d arrived with none outstanding: %h", n_results, got);
			end else begin
				want = result_q.pop_front();
				bad = "";
				if (got.popped_valid !== want.popped_valid) bad = {bad, " popped_valid"};
				if (got.popped_key !== want.popped_key)     bad = {bad, " popped_key"};
				if (got.popped_value !== want.popped_value) bad = {bad, " popped_value"};
				if (got.conflated !== want.conflated)       bad = {bad, " conflated"};
				if (got.evicted !== want.evicted)           bad = {bad, " evicted"};
				if (got.entry_count !== want.entry_count)   bad = {bad, " entry_count"};
				if (got.is_empty !== want.is_empty)         bad = {bad, " is_empty"};
				if (got.is_full !== want.is_full)           bad = {bad, " is_full"};
				if (got.pad !== want.pad)                   bad = {bad, " padding"};
				if (bad != "") begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d wrong in%s: expected %h, got %h",
							n_results, bad, want, got);
				end
			end
		end
	end

	// The run is abandoned when nothing moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timed out with %0d results outstanding", result_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		cf_func_t f;
		logic [15:0] k;
		int n_items, p, push_pct, pool_n, len;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		stall_pat = 16'hFFFF;
		pat_age = 0;
		no_stall = 1'b0;
		burst_left = 0;
		idle_cycles = 0;
		head = 0;
		fill = 0;
		cap_reg = CAP_RESET;
		foreach (slot_busy[i])
			slot_busy[i] = 1'b0;

		// Directed requests: empty pops, extreme keys and values, overwrite, eviction,
		// capacity of zero, above the depth, and lowered below the count.
		dir_tab.push_back(req_row(FUNC_POP, 16'h0000, 32'h0, 1, outcome(0, 0, 0, 0, 0, 0, 0)));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'h0000, 32'h8000_0000, 1,
			outcome(0, 0, 0, 0, 0, 1, 0)));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'hFFFF, 32'h7FFF_FFFF, 1,
			outcome(0, 0, 0, 0, 0, 2, 0)));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'h0000, 32'hFFFF_FFFF, 1,
			outcome(0, 0, 0, 1, 0, 2, 0)));
		dir_tab.push_back(req_row(FUNC_POP, 16'h0000, 32'h0, 1,
			outcome(1, 16'h0000, 32'hFFFF_FFFF, 0, 0, 1, 0)));
		dir_tab.push_back(req_row(FUNC_POP, 16'h0000, 32'h0, 1,
			outcome(1, 16'hFFFF, 32'h7FFF_FFFF, 0, 0, 0, 0)));
		dir_tab.push_back(req_row(FUNC_POP, 16'hFFFF, 32'hFFFF_FFFF, 1,
			outcome(0, 0, 0, 0, 0, 0, 0)));
		dir_tab.push_back(cap_row(2));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'd5, 32'd1, 1, outcome(0, 0, 0, 0, 0, 1, 0)));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'd6, 32'd2, 1, outcome(0, 0, 0, 0, 0, 2, 1)));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'd7, 32'd3, 1, outcome(0, 0, 0, 0, 1, 2, 1)));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'd6, 32'd4, 1, outcome(0, 0, 0, 1, 0, 2, 1)));
		dir_tab.push_back(req_row(FUNC_POP, 16'd0, 32'd0, 1, outcome(1, 6, 4, 0, 0, 1, 0)));
		dir_tab.push_back(cap_row(0));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'd7, 32'd9, 0, '0));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'd8, 32'd10, 1, outcome(0, 0, 0, 0, 1, 1, 1)));
		dir_tab.push_back(cap_row(31));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'd9, 32'd11, 0, '0));
		dir_tab.push_back(cap_row(1));
		dir_tab.push_back(req_row(FUNC_PUSH, 16'd10, 32'd12, 1, outcome(0, 0, 0, 0, 1, 2, 1)));
		dir_tab.push_back(req_row(FUNC_POP, 16'd0, 32'd0, 0, '0));
		dir_tab.push_back(req_row(FUNC_POP, 16'd0, 32'd0, 1, outcome(1, 10, 12, 0, 0, 0, 0)));
		dir_tab.push_back(cap_row(16));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CAP) begin
				settle();
				write_capacity(dir_tab[i].value[4:0]);
			end else begin
				send_req(dir_tab[i].func, dir_tab[i].key, dir_tab[i].value,
					dir_tab[i].typed, dir_tab[i].want);
			end
		end

		// Random phases, each with its own capacity, key pool, request mix and pacing.
		n_items = 0;
		p = 0;
		while (n_items < RAND_ITEMS) begin
			settle();
			write_capacity((p < 10) ? 5'(phase_caps[p]) : 5'($urandom_range(0, 31)));
			no_stall = (p % 4 == 3);
			push_pct = $urandom_range(35, 85);
			pool_n = $urandom_range(2, 24);
			foreach (key_pool[i])
				key_pool[i] = 16'($urandom);
			len = $urandom_range(110, 160);
			repeat (len) begin
				if ($urandom_range(0, 199) == 0)
					settle();
				f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
				k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, pool_n - 1)]
					: 16'($urandom);
				send_req(f, k, $urandom, 1'b0, '0);
				n_items++;
			end
			p++;
		end

		// Drain and let the pipeline run empty before the verdict.
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d pushes (%0d overwrites, %0d evictions) and %0d pops (%0d empty)",
			n_push, n_conf, n_evict, n_pop, n_empty_pop);
		$display("over %0d capacity writes; %0d results checked, %0d mismatches.",
			n_cfg, n_results, mismatches);
		if (mismatches == 0 && result_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
